FILE: hdl/rgb_frame_transpose_defines.svh
// Assertion macros shared by the frame transpose checker.
`ifndef RGB_FRAME_TRANSPOSE_DEFINES_SVH
`define RGB_FRAME_TRANSPOSE_DEFINES_SVH

// Same-cycle implication, masked while reset is active.
`define RFT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_frame_transpose check failed");

// Next-cycle implication, masked while reset is active.
`define RFT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_frame_transpose check failed");

// Next-cycle implication that is also checked through reset.
`define RFT_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rgb_frame_transpose reset check failed");

`endif

FILE: hdl/rft_pkg.sv
// Shared constants and types of the RGB frame transpose block.
`timescale 1ns / 1ps
`default_nettype none

package rft_pkg;

  // Default geometry of the frame store.
  localparam int FRAME_MAX_DIM    = 64;
  localparam int FRAME_MAX_PIXELS = 4096;

  // Configuration port layout and register reset value.
  localparam int CFG_DATA_W    = 7;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DIM_RESET = 64;

  // Depths of the command queue and the result queue.
  localparam int CMD_FIFO_DEPTH = 4;
  localparam int RES_FIFO_DEPTH = 4;

  localparam int CHAN_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_DRAIN = 1'b1
  } opcode_t;

  // Work handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_BLANK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      hit;
    logic      last;
  } cmd_ctrl_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic   valid;
    pixel_t pixel;
    logic   last;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/rft_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rft_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire  logic                     clk,
  input  wire  logic                     en,
  input  wire  logic                     we,
  input  wire  logic [$clog2(DEPTH)-1:0] addr,
  input  wire  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One access per cycle, either a write or a read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/rft_fifo.sv
// Small flip-flop queue used for commands and for results.
`timescale 1ns / 1ps
`default_nettype none

module rft_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire  logic                       clk,
  input  wire  logic                       rst_n,
  input  wire  logic                       push,
  input  wire  logic [WIDTH-1:0]           push_data,
  input  wire  logic                       pop,
  output logic [WIDTH-1:0]                 pop_data,
  output logic                             full,
  output logic                             empty,
  output logic [$clog2(DEPTH+1)-1:0]       count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH-1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rft_front.sv
// Front end: configuration registers, load counting and transposed address generation.
`timescale 1ns / 1ps
`default_nettype none

module rft_front import rft_pkg::*; #(
  parameter int MAX_DIM    = FRAME_MAX_DIM,
  parameter int MAX_PIXELS = FRAME_MAX_PIXELS
) (
  input  wire  logic                          clk,
  input  wire  logic                          rst_n,
  input  wire  logic                          cfg_valid,
  input  wire  logic [CFG_IDX_W-1:0]          cfg_index,
  input  wire  logic [CFG_DATA_W-1:0]         cfg_data,
  input  wire  logic                          item_valid,
  input  wire  logic                          item_opcode,
  input  wire  pixel_t                        item_pixel,
  output logic                                cmd_push,
  output cmd_ctrl_t                           cmd_ctrl,
  output logic [$clog2(MAX_PIXELS)-1:0]       cmd_addr,
  output pixel_t                              cmd_pixel
);

  localparam int DIM_W     = $clog2(MAX_DIM+1);
  localparam int ROW_W     = $clog2(MAX_DIM);
  localparam int CNT_W     = 2 * DIM_W;
  localparam int RAM_AW    = $clog2(MAX_PIXELS);
  localparam int RESET_DIM = (CFG_DIM_RESET > MAX_DIM) ? MAX_DIM : CFG_DIM_RESET;

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [CNT_W-1:0] area_r, area_nxt;
  logic [CNT_W-1:0] load_count_r, load_count_nxt;
  logic             phase_r, phase_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [ROW_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] addr_r, addr_nxt;

  logic draining;
  logic row_end;
  logic col_end;
  logic last;

  // A zero register acts as one, anything above MAX_DIM as MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [31:0] vv;
    vv = 32'(v);
    if (vv == 32'd0) begin
      return DIM_W'(1);
    end else if (vv > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end
    return DIM_W'(vv);
  endfunction

  // Register writes; the frame area is recomputed on every write.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  width_nxt  = clamp_dim(cfg_data);
        REG_FRAME_HEIGHT: height_nxt = clamp_dim(cfg_data);
        default:          ;
      endcase
    end
    area_nxt = CNT_W'(width_nxt) * CNT_W'(height_nxt);
  end

  // A full frame switches to draining even if the phase bit has not caught up.
  assign draining = phase_r || (load_count_r >= area_r);
  assign row_end  = (DIM_W'(row_r) + DIM_W'(1)) >= height_r;
  assign col_end  = (DIM_W'(col_r) + DIM_W'(1)) >= width_r;
  assign last     = row_end && col_end;

  // Classify the item and step the load counter or the drain walk.
  always_comb begin
    load_count_nxt = load_count_r;
    phase_nxt      = phase_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    addr_nxt       = addr_r;
    cmd_push       = 1'b0;
    cmd_ctrl       = '{kind: CMD_WRITE, hit: 1'b0, last: 1'b0};
    cmd_addr       = '0;
    cmd_pixel      = item_pixel;
    if (item_valid) begin
      if (item_opcode == OP_LOAD) begin
        if (!draining) begin
          cmd_push       = (32'(load_count_r) < MAX_PIXELS);
          cmd_addr       = RAM_AW'(load_count_r);
          load_count_nxt = load_count_r + CNT_W'(1);
          phase_nxt      = (load_count_r + CNT_W'(1)) >= area_r;
        end else begin
          // Loads during draining are dropped.
          phase_nxt = 1'b1;
        end
      end else if (!draining) begin
        cmd_push      = 1'b1;
        cmd_ctrl.kind = CMD_BLANK;
      end else begin
        cmd_push      = 1'b1;
        cmd_ctrl.kind = CMD_READ;
        cmd_ctrl.hit  = (32'(addr_r) < MAX_PIXELS);
        cmd_ctrl.last = last;
        cmd_addr      = RAM_AW'(addr_r);
        if (last) begin
          phase_nxt      = 1'b0;
          load_count_nxt = '0;
          row_nxt        = '0;
          col_nxt        = '0;
          addr_nxt       = '0;
        end else if (row_end) begin
          phase_nxt = 1'b1;
          row_nxt   = '0;
          col_nxt   = col_r + ROW_W'(1);
          addr_nxt  = CNT_W'(col_r) + CNT_W'(1);
        end else begin
          phase_nxt = 1'b1;
          row_nxt   = row_r + ROW_W'(1);
          addr_nxt  = addr_r + CNT_W'(width_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= DIM_W'(RESET_DIM);
      height_r     <= DIM_W'(RESET_DIM);
      area_r       <= CNT_W'(RESET_DIM * RESET_DIM);
      load_count_r <= '0;
      phase_r      <= 1'b0;
      row_r        <= '0;
      col_r        <= '0;
      addr_r       <= '0;
    end else begin
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      area_r       <= area_nxt;
      load_count_r <= load_count_nxt;
      phase_r      <= phase_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      addr_r       <= addr_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rft_back.sv
// Back end: frame store accesses and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module rft_back import rft_pkg::*; #(
  parameter int MAX_PIXELS = FRAME_MAX_PIXELS
) (
  input  wire  logic                          clk,
  input  wire  logic                          rst_n,
  input  wire  logic                          cmd_empty,
  input  wire  cmd_ctrl_t                     cmd_ctrl,
  input  wire  logic [$clog2(MAX_PIXELS)-1:0] cmd_addr,
  input  wire  pixel_t                        cmd_pixel,
  output logic                                cmd_pop,
  input  wire  logic                          res_pop,
  output logic                                res_empty,
  output result_t                             res_head
);

  localparam int RES_CNT_W = $clog2(RES_FIFO_DEPTH+1);
  localparam int RES_W     = $bits(result_t);

  logic [RES_CNT_W-1:0] res_count;
  logic [RES_W-1:0]     res_head_bits;
  logic                 res_room;
  logic                 is_write;
  logic                 ram_en;
  pixel_t               ram_rdata;
  result_t              res_in;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_read_r;
  logic s1_hit_r;
  logic s1_last_r;

  // Results in flight plus queued ones must fit in the result queue.
  assign res_room = (32'(res_count) + 32'(s1_valid_r)) < RES_FIFO_DEPTH;
  assign is_write = (cmd_ctrl.kind == CMD_WRITE);
  assign cmd_pop  = !cmd_empty && (is_write || res_room);
  assign ram_en   = cmd_pop && (is_write || (cmd_ctrl.kind == CMD_READ && cmd_ctrl.hit));
  assign s1_valid_nxt = cmd_pop && !is_write;

  rft_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (MAX_PIXELS)
  ) u_frame_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (is_write),
    .addr  (cmd_addr),
    .wdata (cmd_pixel),
    .rdata (ram_rdata)
  );

  // Result stage, aligned with the registered store read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_read_r <= (cmd_ctrl.kind == CMD_READ);
      s1_hit_r  <= cmd_ctrl.hit;
      s1_last_r <= cmd_ctrl.last;
    end
  end

  // Reads past the store and blank results give zero pixels.
  always_comb begin
    res_in.valid = s1_read_r;
    res_in.pixel = (s1_read_r && s1_hit_r) ? ram_rdata : '0;
    res_in.last  = s1_read_r && s1_last_r;
  end

  rft_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (res_in),
    .pop       (res_pop),
    .pop_data  (res_head_bits),
    .full      (),
    .empty     (res_empty),
    .count     (res_count)
  );

  assign res_head = result_t'(res_head_bits);

endmodule

`default_nettype wire

FILE: hdl/rgb_frame_transpose.sv
// Top level of the RGB frame transpose block.
//
// Pixels enter through a queue-style port: a transfer happens when in_push is
// high and in_full is low. A load item (opcode 0) writes the next pixel of the
// frame in row-major order; a drain item (opcode 1) returns the next pixel in
// transposed order, with out_last_pixel set on the final one, after which the
// block loads a new frame. Drains before the frame is full return out_valid 0.
// Frame width and height are to be written through the cfg port only while the
// block idles; the block itself does not enforce this. Results leave through a
// queue-style port: the oldest result sits on the out_ ports while out_empty is
// low and is taken by a transfer with out_pop high. The block takes one item per
// cycle while in_full is low, bound by the single-port frame store that serves
// at most one write or one read per item. A stalled receiver fills the result
// queue; the back end then stops taking commands and in_full rises once the
// command queue is full. Reset empties both queues and restarts loading; the
// frame store is not cleared, so no clearing pass runs after reset.
`timescale 1ns / 1ps
`default_nettype none

module rgb_frame_transpose import rft_pkg::*; #(
  parameter int MAX_DIM    = FRAME_MAX_DIM,
  parameter int MAX_PIXELS = FRAME_MAX_PIXELS
) (
  input  wire  logic                  clk,
  input  wire  logic                  rst_n,
  input  wire  logic                  cfg_valid,
  output logic                        cfg_ready,
  input  wire  logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire  logic [CFG_DATA_W-1:0] cfg_data,
  input  wire  logic                  in_push,
  output logic                        in_full,
  input  wire  logic                  in_opcode,
  input  wire  logic [CHAN_W-1:0]     in_red_in,
  input  wire  logic [CHAN_W-1:0]     in_green_in,
  input  wire  logic [CHAN_W-1:0]     in_blue_in,
  output logic                        out_empty,
  input  wire  logic                  out_pop,
  output logic                        out_valid,
  output logic [CHAN_W-1:0]           out_red_out,
  output logic [CHAN_W-1:0]           out_green_out,
  output logic [CHAN_W-1:0]           out_blue_out,
  output logic                        out_last_pixel
);

  localparam int RAM_AW = $clog2(MAX_PIXELS);
  localparam int CTL_W  = $bits(cmd_ctrl_t);
  localparam int PIX_W  = $bits(pixel_t);
  localparam int CMD_W  = CTL_W + RAM_AW + PIX_W;

  logic              item_valid;
  pixel_t            item_pixel;
  logic              front_push;
  cmd_ctrl_t         front_ctrl;
  logic [RAM_AW-1:0] front_addr;
  pixel_t            front_pixel;
  logic [CMD_W-1:0]  cmd_wdata;
  logic [CMD_W-1:0]  cmd_rdata;
  logic              cmd_empty;
  logic              cmd_pop;
  cmd_ctrl_t         back_ctrl;
  logic [RAM_AW-1:0] back_addr;
  pixel_t            back_pixel;
  result_t           res_head;

  // Register writes are always taken.
  assign cfg_ready  = 1'b1;
  assign item_valid = in_push && !in_full;
  assign item_pixel = '{red: in_red_in, green: in_green_in, blue: in_blue_in};

  rft_front #(
    .MAX_DIM    (MAX_DIM),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_opcode (in_opcode),
    .item_pixel  (item_pixel),
    .cmd_push    (front_push),
    .cmd_ctrl    (front_ctrl),
    .cmd_addr    (front_addr),
    .cmd_pixel   (front_pixel)
  );

  // Command queue between the front end and the back end.
  assign cmd_wdata = {front_ctrl, front_addr, front_pixel};

  rft_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data (cmd_wdata),
    .pop       (cmd_pop),
    .pop_data  (cmd_rdata),
    .full      (in_full),
    .empty     (cmd_empty),
    .count     ()
  );

  assign back_ctrl  = cmd_ctrl_t'(cmd_rdata[CMD_W-1 -: CTL_W]);
  assign back_addr  = cmd_rdata[PIX_W +: RAM_AW];
  assign back_pixel = pixel_t'(cmd_rdata[PIX_W-1:0]);

  rft_back #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_ctrl  (back_ctrl),
    .cmd_addr  (back_addr),
    .cmd_pixel (back_pixel),
    .cmd_pop   (cmd_pop),
    .res_pop   (out_pop),
    .res_empty (out_empty),
    .res_head  (res_head)
  );

  assign out_valid      = res_head.valid;
  assign out_red_out    = res_head.pixel.red;
  assign out_green_out  = res_head.pixel.green;
  assign out_blue_out   = res_head.pixel.blue;
  assign out_last_pixel = res_head.last;

endmodule

`default_nettype wire

FILE: hdl/rft_checker.sv
// Port-level checks of the RGB frame transpose block and their binding.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_frame_transpose_defines.svh"

module rft_checker import rft_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_full,
  input wire logic              out_empty,
  input wire logic              out_pop,
  input wire logic              out_valid,
  input wire logic [CHAN_W-1:0] out_red_out,
  input wire logic [CHAN_W-1:0] out_green_out,
  input wire logic [CHAN_W-1:0] out_blue_out,
  input wire logic              out_last_pixel
);

  // A drain before the frame is full carries an all-zero pixel and no last flag.
  `RFT_ASSERT_IMP(a_blank_result_zero, !out_empty && !out_valid, out_red_out == 8'd0 && out_green_out == 8'd0 && out_blue_out == 8'd0 && !out_last_pixel)

  // The last-pixel flag only comes with a real pixel.
  `RFT_ASSERT_IMP(a_last_needs_valid, !out_empty && out_last_pixel, out_valid)

  // A waiting result holds until it is transferred.
  `RFT_ASSERT_NXT(a_result_holds, !out_empty && !out_pop, !out_empty && $stable(out_valid) && $stable(out_red_out) && $stable(out_green_out) && $stable(out_blue_out) && $stable(out_last_pixel))

  // Reset leaves both queues empty.
  `RFT_ASSERT_RST(a_reset_empties, !rst_n, out_empty && !in_full)

endmodule

bind rgb_frame_transpose rft_checker u_rft_checker (.*);

`default_nettype wire

FILE: sim/rft_transpose_monitor.sv
// Transfer monitor with a frame transpose predictor and result comparison.
`timescale 1ns / 1ps

module rft_transpose_monitor import rft_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_push,
  input  logic                  in_full,
  input  logic                  in_opcode,
  input  logic [CHAN_W-1:0]     in_red_in,
  input  logic [CHAN_W-1:0]     in_green_in,
  input  logic [CHAN_W-1:0]     in_blue_in,
  input  logic                  out_empty,
  input  logic                  out_pop,
  input  logic                  out_valid,
  input  logic [CHAN_W-1:0]     out_red_out,
  input  logic [CHAN_W-1:0]     out_green_out,
  input  logic [CHAN_W-1:0]     out_blue_out,
  input  logic                  out_last_pixel,
  output int                    failures,
  output int                    pending,
  output logic                  frame_loading
);

  // Shadow copy of the block state.
  pixel_t                frame_mem [FRAME_MAX_PIXELS];
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  logic [12:0]           pixels_loaded;
  logic                  draining;
  logic [5:0]            rd_row;
  logic [5:0]            rd_col;
  logic [11:0]           rd_addr;
  result_t               expected_pixels [$];

  // A zero register acts as one, anything above the maximum as the maximum.
  function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > FRAME_MAX_DIM) return FRAME_MAX_DIM;
    return int'(v);
  endfunction

  task automatic enter_drain();
    draining = 1'b1;
    rd_row   = '0;
    rd_col   = '0;
    rd_addr  = '0;
  endtask

  // Advance the shadow state by one item and queue the result it causes.
  task automatic transpose_step(input opcode_t op, input pixel_t px);
    int      w;
    int      h;
    logic    last;
    result_t res;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    // A frame made full by a register change starts draining on the next item.
    if (!draining && int'(pixels_loaded) >= w * h) enter_drain();
    if (op == OP_LOAD) begin
      if (!draining) begin
        frame_mem[pixels_loaded] = px;
        pixels_loaded++;
        if (int'(pixels_loaded) >= w * h) enter_drain();
      end
    end else if (!draining) begin
      // Drain before the frame is full returns an all-zero result.
      res = '0;
      expected_pixels.push_back(res);
    end else begin
      last = (int'(rd_row) + 1 >= h) && (int'(rd_col) + 1 >= w);
      res.valid = 1'b1;
      res.pixel = frame_mem[rd_addr];
      res.last  = last;
      expected_pixels.push_back(res);
      if (last) begin
        draining      = 1'b0;
        pixels_loaded = '0;
        rd_row        = '0;
        rd_col        = '0;
        rd_addr       = '0;
      end else if (int'(rd_row) + 1 >= h) begin
        rd_row  = '0;
        rd_col  = rd_col + 1'b1;
        rd_addr = 12'(rd_col);
      end else begin
        rd_row  = rd_row + 1'b1;
        rd_addr = rd_addr + 12'(w);
      end
    end
  endtask

  // Compare one result transfer with the oldest expected pixel.
  task automatic check_pixel();
    result_t seen;
    result_t want;
    seen.valid       = out_valid;
    seen.pixel.red   = out_red_out;
    seen.pixel.green = out_green_out;
    seen.pixel.blue  = out_blue_out;
    seen.last        = out_last_pixel;
    if (expected_pixels.size() == 0) begin
      $display("%0t: result with nothing expected, actual valid=%0b rgb=%h_%h_%h last=%0b",
               $time, seen.valid, seen.pixel.red, seen.pixel.green, seen.pixel.blue,
               seen.last);
      failures++;
    end else begin
      want = expected_pixels.pop_front();
      if (seen !== want) begin
        $display("%0t: mismatch, expected valid=%0b rgb=%h_%h_%h last=%0b, actual valid=%0b rgb=%h_%h_%h last=%0b",
                 $time, want.valid, want.pixel.red, want.pixel.green, want.pixel.blue,
                 want.last, seen.valid, seen.pixel.red, seen.pixel.green,
                 seen.pixel.blue, seen.last);
        failures++;
      end
    end
  endtask

  // Sample every channel at the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg     = CFG_DATA_W'(CFG_DIM_RESET);
      height_reg    = CFG_DATA_W'(CFG_DIM_RESET);
      pixels_loaded = '0;
      draining      = 1'b0;
      rd_row        = '0;
      rd_col        = '0;
      rd_addr       = '0;
      failures      = 0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready === 1'b1) begin
        if (cfg_index == REG_FRAME_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_FRAME_HEIGHT) height_reg = cfg_data;
      end
      if (out_pop && out_empty === 1'b0) check_pixel();
      if (in_push && in_full === 1'b0) begin
        transpose_step(opcode_t'(in_opcode), pixel_t'({in_red_in, in_green_in, in_blue_in}));
      end
    end
    pending       = expected_pixels.size();
    frame_loading = !draining;
  end

endmodule

FILE: sim/tb_rgb_frame_transpose.sv
// Top of the frame transpose testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_rgb_frame_transpose;
  import rft_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int LONG_HOLD     = 100;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 750;
  localparam int TAIL_ITEMS    = 80;
  localparam int HOLD_HEIGHT   = 2;
  localparam logic [CFG_IDX_W-1:0]  REG_SPARE = '1;
  localparam logic [CFG_DATA_W-1:0] DIM_CODE_MAX = '1;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_push     = 1'b0;
  logic                  in_opcode   = 1'b0;
  logic [CHAN_W-1:0]     in_red_in   = '0;
  logic [CHAN_W-1:0]     in_green_in = '0;
  logic [CHAN_W-1:0]     in_blue_in  = '0;
  logic                  out_pop     = 1'b0;
  logic                  cfg_ready;
  logic                  in_full;
  logic                  out_empty;
  logic                  out_valid;
  logic [CHAN_W-1:0]     out_red_out;
  logic [CHAN_W-1:0]     out_green_out;
  logic [CHAN_W-1:0]     out_blue_out;
  logic                  out_last_pixel;

  int   failures;
  int   pending;
  logic frame_loading;

  // Idling control shared by the sender and the receiver.
  bit gaps_on       = 1'b1;
  bit calm_phase    = 1'b0;
  int hold_requests = 0;
  int holds_seen    = 0;
  int hold_left     = 0;
  int burst_left    = 0;

  int cycle_count    = 0;
  int items_sent     = 0;
  int settings_used  = 0;
  int width_now      = CFG_DIM_RESET;
  int height_now     = CFG_DIM_RESET;

  rgb_frame_transpose uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_valid      (out_valid),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_last_pixel (out_last_pixel)
  );

  rft_transpose_monitor pixel_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_opcode      (in_opcode),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_valid      (out_valid),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_last_pixel (out_last_pixel),
    .failures       (failures),
    .pending        (pending),
    .frame_loading  (frame_loading)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rgb_frame_transpose regression: fail");
      $finish;
    end
  end

  // Receiver: a requested long hold-off, short random stalls, otherwise pop.
  always @(negedge clk) begin
    if (hold_requests != holds_seen) begin
      holds_seen = hold_requests;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_pop <= 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_pop <= 1'b0;
    end else if (gaps_on && !calm_phase && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(1, 4) - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  function automatic pixel_t random_pixel();
    logic [23:0] raw;
    raw = 24'($urandom);
    return raw;
  endfunction

  // Written code for a frame size; sizes at the limits sometimes use out-of-range codes.
  function automatic logic [CFG_DATA_W-1:0] encode_dim(input int dim);
    if (dim == 1 && $urandom_range(0, 2) == 0) return '0;
    if (dim == FRAME_MAX_DIM && $urandom_range(0, 1) == 0) begin
      return CFG_DATA_W'($urandom_range(FRAME_MAX_DIM + 1, int'(DIM_CODE_MAX)));
    end
    return CFG_DATA_W'(dim);
  endfunction

  // Offer one item, with an occasional idle burst first; entered and left at a falling edge.
  task automatic push_item(input opcode_t op, input pixel_t px);
    int gap;
    if (gaps_on && !calm_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push     <= 1'b1;
    in_opcode   <= op;
    in_red_in   <= px.red;
    in_green_in <= px.green;
    in_blue_in  <= px.blue;
    do @(posedge clk); while (in_full !== 1'b0);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Hold the sender until every expected result has come, then let loads settle.
  task automatic wait_idle();
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Drain until the block is back in the loading phase.
  task automatic finish_frame();
    while (!frame_loading) push_item(OP_DRAIN, random_pixel());
  endtask

  // One random frame: mostly well-formed load and drain runs with some noise.
  task automatic run_random_frame();
    int pick;
    int new_w;
    int new_h;
    int area;
    int n_load;
    int n_drain;
    calm_phase = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 3) != 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        new_w = $urandom_range(1, 8);
        new_h = $urandom_range(1, 8);
      end else if (pick == 7) begin
        new_w = $urandom_range(1, 2);
        new_h = $urandom_range(1, 32);
      end else if (pick == 8) begin
        new_w = FRAME_MAX_DIM;
        new_h = $urandom_range(1, 2);
      end else begin
        new_w = $urandom_range(1, 2);
        new_h = FRAME_MAX_DIM;
      end
      finish_frame();
      wait_idle();
      // Sometimes only one register changes, possibly in the middle of a frame.
      pick = $urandom_range(0, 9);
      if (pick != 0) begin
        write_reg(REG_FRAME_WIDTH, encode_dim(new_w));
        width_now = new_w;
      end
      if (pick != 1) begin
        write_reg(REG_FRAME_HEIGHT, encode_dim(new_h));
        height_now = new_h;
      end
      settings_used++;
    end
    area   = width_now * height_now;
    n_load = ($urandom_range(0, 6) == 0) ? $urandom_range(0, area - 1) : area;
    for (int i = 0; i < n_load; i++) begin
      if ($urandom_range(0, 11) == 0) push_item(OP_DRAIN, random_pixel());
      push_item(OP_LOAD, random_pixel());
    end
    if (n_load == area) begin
      n_drain = ($urandom_range(0, 9) == 0) ? $urandom_range(1, area) : area;
      for (int i = 0; i < n_drain; i++) begin
        if ($urandom_range(0, 11) == 0) push_item(OP_LOAD, random_pixel());
        push_item(OP_DRAIN, random_pixel());
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    bit hold_done;
    int mark;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset size: drains before the frame is full, then extreme pixel values.
    push_item(OP_DRAIN, random_pixel());
    push_item(OP_LOAD, pixel_t'{8'hFF, 8'h00, 8'hFF});
    push_item(OP_LOAD, pixel_t'{8'h00, 8'hFF, 8'h00});
    push_item(OP_LOAD, pixel_t'{8'h00, 8'h00, 8'h00});
    push_item(OP_LOAD, pixel_t'{8'hFF, 8'hFF, 8'hFF});
    push_item(OP_LOAD, random_pixel());
    push_item(OP_DRAIN, random_pixel());

    // Shrink to 2x2 mid-frame: already full, so the next load is dropped.
    wait_idle();
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
    width_now  = 2;
    height_now = 2;
    settings_used++;
    push_item(OP_LOAD, random_pixel());
    repeat (4) push_item(OP_DRAIN, random_pixel());
    push_item(OP_DRAIN, random_pixel());

    // A zero width acts as one; a load while draining is dropped.
    wait_idle();
    write_reg(REG_FRAME_WIDTH, '0);
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
    width_now  = 1;
    height_now = 3;
    settings_used++;
    repeat (3) push_item(OP_LOAD, random_pixel());
    push_item(OP_LOAD, random_pixel());
    repeat (3) push_item(OP_DRAIN, random_pixel());

    // Random frames, with one full-width frame drained under a long output hold-off.
    mark      = items_sent;
    hold_done = 1'b0;
    while (items_sent - mark < RANDOM_ITEMS) begin
      if (!hold_done && items_sent - mark > RANDOM_ITEMS / 3) begin
        hold_done = 1'b1;
        finish_frame();
        wait_idle();
        write_reg(REG_FRAME_WIDTH, DIM_CODE_MAX);
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(HOLD_HEIGHT));
        width_now  = FRAME_MAX_DIM;
        height_now = HOLD_HEIGHT;
        settings_used++;
        calm_phase = 1'b0;
        repeat (FRAME_MAX_DIM * HOLD_HEIGHT) push_item(OP_LOAD, random_pixel());
        hold_requests++;
        repeat (FRAME_MAX_DIM * HOLD_HEIGHT) push_item(OP_DRAIN, random_pixel());
      end
      if (items_sent - mark > RANDOM_ITEMS - TAIL_ITEMS) gaps_on = 1'b0;
      run_random_frame();
    end

    wait_idle();
    $display("Covered %0d items over %0d frame sizes, with blank drains, dropped loads",
             items_sent, settings_used);
    $display("and a full-width frame drained while the receiver held off.");
    if (failures == 0) begin
      $display("rgb_frame_transpose regression: pass");
    end else begin
      $display("rgb_frame_transpose regression: fail");
    end
    $finish;
  end

endmodule

FILE: rgb_frame_transpose.f
+incdir+hdl
hdl/rft_pkg.sv
hdl/rft_ram.sv
hdl/rft_fifo.sv
hdl/rft_front.sv
hdl/rft_back.sv
hdl/rgb_frame_transpose.sv
hdl/rft_checker.sv
sim/rft_transpose_monitor.sv
sim/tb_rgb_frame_transpose.sv
